@@ design/cst_pkg.sv @@
// Shared types, constants and a helper function for the compacting symbol table.
`default_nettype none

package cst_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int SYMBOL_W = 8;
   localparam int ENTRY_W  = 6;
   localparam int HELD_W   = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_MODIFY = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TY_IDENT = 2'd0,
      TY_OPER  = 2'd1,
      TY_MOD   = 2'd2
   } kind_type;

   typedef struct packed {
      logic                do_insert;
      logic                do_delete;
      logic                do_modify;
      logic [SYMBOL_W-1:0] symbol;
      logic [COUNT_W-1:0]  count;
   } ctrl_type;

   localparam logic [SYMBOL_W-1:0] CASE_BIT = 8'h20;
   localparam logic [SYMBOL_W-1:0] LOWER_A  = 8'h61;
   localparam logic [SYMBOL_W-1:0] LOWER_Z  = 8'h7a;

   function automatic kind_type classify(input logic [SYMBOL_W-1:0] s);
      logic [SYMBOL_W-1:0] low;
      low = s | CASE_BIT;
      return ((low >= LOWER_A) && (low <= LOWER_Z)) ? TY_IDENT : TY_OPER;
   endfunction

endpackage

`default_nettype wire

@@ design/cst_cell.sv @@
// One table cell: holds one symbol and its type, compares and shifts from its neighbour.
`default_nettype none

module cst_cell (
   input  wire logic                         clock,
   input  wire logic [cst_pkg::COUNT_W-1:0]  cell_index,
   input  wire cst_pkg::ctrl_type            ctrl,
   input  wire logic                         first,
   input  wire logic                         below,
   input  wire logic [cst_pkg::SYMBOL_W-1:0] next_symbol,
   input  wire cst_pkg::kind_type            next_kind,
   output logic [cst_pkg::SYMBOL_W-1:0]      symbol,
   output cst_pkg::kind_type                 kind,
   output logic                              match
);
   import cst_pkg::*;

   logic [SYMBOL_W-1:0] symbol_ff;
   kind_type            kind_ff;
   logic                match_ff;

   always_ff @(posedge clock) begin
      match_ff <= (symbol_ff == ctrl.symbol) && (cell_index < ctrl.count);
      if (ctrl.do_insert && (cell_index == ctrl.count)) begin
         symbol_ff <= ctrl.symbol;
         kind_ff   <= classify(ctrl.symbol);
      end else if (ctrl.do_delete && !below) begin
         symbol_ff <= next_symbol;
         kind_ff   <= next_kind;
      end else if (ctrl.do_modify && first) begin
         kind_ff <= TY_MOD;
      end
   end

   assign symbol = symbol_ff;
   assign kind   = kind_ff;
   assign match  = match_ff;

endmodule

`default_nettype wire

@@ design/compacting_symbol_table_top.sv @@
// Top level of the compacting symbol table: request control, match selection and cell row.
//
// A request is a transaction taken when start is high and busy is low; it carries a
// command (insert, delete, search or modify type) and a symbol byte. Every request
// yields one result, shown on the rsp_ ports for exactly one cycle while rsp_valid is
// high: a status, the entry index, the entry type and the number of entries held.
// Entries sit in a row of cells, each holding one symbol and its type. In the cycle
// after acceptance every cell compares its symbol with the request; in the next cycle
// the lowest matching cell is picked by a carry chain over the match vector; in the
// third the result is formed and the cells update, with a delete moving every later
// entry down one cell from its neighbour in that same cycle.
// The result is registered at the end of the update step, and busy falls in the cycle the
// result is shown, so a new request can be taken while the result is shown. No new request
// is taken while one is in the compare, select or update step through the cell row.
// A synchronous reset empties the table at once; no clearing pass is needed, as cells
// at or above the entry count are never read. The receiver cannot stall, so results
// are never held back.
`default_nettype none

module compacting_symbol_table_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_command,
   input  wire logic [cst_pkg::SYMBOL_W-1:0] req_symbol,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [cst_pkg::ENTRY_W-1:0]       rsp_entry_index,
   output logic [1:0]                        rsp_entry_type,
   output logic [cst_pkg::HELD_W-1:0]        rsp_entries_held
);
   import cst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SEL  = 4'b0100,
      S_UPD  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   command_type         command_ff;
   logic [SYMBOL_W-1:0] symbol_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] first_ff, below_ff;
   logic [CAPACITY-1:0] match_vec, first_in, below_in;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff, status_in;
   logic [ENTRY_W-1:0]  rsp_index_ff, index_in;
   kind_type            rsp_kind_ff, kind_in;
   logic [HELD_W-1:0]   rsp_held_ff;

   ctrl_type            ctrl;
   logic                hit;
   logic [IDX_W-1:0]    hit_index;
   kind_type            hit_kind;

   logic [SYMBOL_W-1:0] cell_symbol [CAPACITY];
   kind_type            cell_kind   [CAPACITY];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_CMP;
         S_CMP:  state_in = S_SEL;
         S_SEL:  state_in = S_UPD;
         S_UPD:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign first_in = match_vec & (~match_vec + 1'b1);
   assign below_in = (match_vec ^ (match_vec - 1'b1)) & ~first_in;

   always_comb begin
      hit_index = '0;
      hit_kind  = TY_IDENT;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_ff[i]) begin
            hit_index = hit_index | IDX_W'(i);
            hit_kind  = kind_type'(hit_kind | cell_kind[i]);
         end
      end
   end

   assign hit = |first_ff;

   always_comb begin
      ctrl.do_insert = 1'b0;
      ctrl.do_delete = 1'b0;
      ctrl.do_modify = 1'b0;
      ctrl.symbol    = symbol_ff;
      ctrl.count     = count_ff;
      count_in       = count_ff;
      status_in      = ST_MISSING;
      index_in       = '0;
      kind_in        = TY_IDENT;
      if (command_ff == CMD_INSERT) begin
         if (hit) begin
            status_in = ST_DUP;
            index_in  = ENTRY_W'(hit_index);
            kind_in   = hit_kind;
         end else if (count_ff >= COUNT_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            status_in      = ST_DONE;
            index_in       = ENTRY_W'(count_ff);
            kind_in        = classify(symbol_ff);
            count_in       = count_ff + 1'b1;
            ctrl.do_insert = (state_ff == S_UPD);
         end
      end else if (hit) begin
         status_in = ST_DONE;
         index_in  = ENTRY_W'(hit_index);
         unique case (command_ff)
            CMD_DELETE: begin
               kind_in        = hit_kind;
               count_in       = count_ff - 1'b1;
               ctrl.do_delete = (state_ff == S_UPD);
            end
            CMD_MODIFY: begin
               kind_in        = TY_MOD;
               ctrl.do_modify = (state_ff == S_UPD);
            end
            default: kind_in = hit_kind;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_UPD);
         if (state_ff == S_UPD) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         command_ff <= command_type'(req_command);
         symbol_ff  <= req_symbol;
      end
      if (state_ff == S_SEL) begin
         first_ff <= first_in;
         below_ff <= below_in;
      end
      if (state_ff == S_UPD) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= index_in;
         rsp_kind_ff   <= kind_in;
         rsp_held_ff   <= HELD_W'(count_in);
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [SYMBOL_W-1:0] next_symbol;
      kind_type            next_kind;
      if (g == CAPACITY - 1) begin : g_last
         assign next_symbol = cell_symbol[g];
         assign next_kind   = cell_kind[g];
      end else begin : g_mid
         assign next_symbol = cell_symbol[g+1];
         assign next_kind   = cell_kind[g+1];
      end
      cst_cell u_cell (
         .clock       (clock),
         .cell_index  (COUNT_W'(g)),
         .ctrl        (ctrl),
         .first       (first_ff[g]),
         .below       (below_ff[g]),
         .next_symbol (next_symbol),
         .next_kind   (next_kind),
         .symbol      (cell_symbol[g]),
         .kind        (cell_kind[g]),
         .match       (match_vec[g])
      );
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_entry_type   = rsp_kind_ff;
   assign rsp_entries_held = rsp_held_ff;

endmodule

`default_nettype wire
